FILE: src/cega_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and mask helper for the contiguous extent grow allocator.
// Used by cega_ctrl, cega_dp and contiguous_extent_grow_allocator_core.
package cega_pkg;

   localparam int DISK_BLOCKS = 32;
   localparam int PosWidth    = $clog2(DISK_BLOCKS + 1);
   localparam int SizeWidth   = ((PosWidth > 6) ? PosWidth : 6) + 1;
   localparam int FieldWidth  = 5;
   localparam int GrowWidth   = 6;
   localparam int StatusWidth = 3;
   localparam int OccWidth    = 32;

   typedef logic [DISK_BLOCKS-1:0] map_type;

   typedef enum logic [StatusWidth-1:0] {
      RSP_WRITTEN   = 3'd0,
      RSP_EXTENDED  = 3'd1,
      RSP_RELOCATED = 3'd2,
      RSP_FAILED    = 3'd3,
      RSP_INVALID   = 3'd4
   } status_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic step;
      logic found;
      logic fail;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic direct;
      logic hit;
      logic in_range;
      logic out_free;
   } sts_type;

   function automatic map_type run_mask(input logic [SizeWidth-1:0] pos,
                                        input logic [SizeWidth-1:0] len);
      map_type ones;
      map_type m;
      ones = '1;
      if (len >= SizeWidth'(DISK_BLOCKS)) begin
         m = ones;
      end else begin
         m = ~(ones << len);
      end
      if (pos >= SizeWidth'(DISK_BLOCKS)) begin
         m = '0;
      end else begin
         m = m << pos;
      end
      return m;
   endfunction

endpackage

FILE: src/cega_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences accept, decision, first-fit scan and result.
// Depends on cega_pkg for the command and status structs.
module cega_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cega_pkg::sts_type sts,
   output cega_pkg::cmd_type cmd
);
   import cega_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SEARCH,
      S_PUBLISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.direct ? S_PUBLISH : S_SEARCH;
         end
         S_SEARCH: begin
            priority if (sts.hit) begin
               cmd.found = 1'b1;
               state_in  = S_PUBLISH;
            end else if (!sts.in_range) begin
               cmd.fail = 1'b1;
               state_in = S_PUBLISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_PUBLISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE)
      else $error("load outside idle");

   a_decide_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.decide)
      else $error("decision did not follow transfer");

   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.found, cmd.fail, cmd.step, cmd.publish, cmd.decide, cmd.load}))
      else $error("conflicting commands");

endmodule

FILE: src/cega_dp.sv
`timescale 1ns / 1ps
// Datapath: occupancy bitmap, request registers, sliding search window and result register.
// Depends on cega_pkg for widths, status codes, structs and run_mask.
module cega_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cega_pkg::cmd_type                     cmd,
   output cega_pkg::sts_type                     sts,
   input  logic                                  req_action,
   input  logic [cega_pkg::FieldWidth-1:0]       req_block_index,
   input  logic                                  req_block_value,
   input  logic [cega_pkg::FieldWidth-1:0]       req_file_start,
   input  logic [cega_pkg::FieldWidth-1:0]       req_file_end,
   input  logic [cega_pkg::GrowWidth-1:0]        req_grow_amount,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cega_pkg::StatusWidth-1:0]      rsp_status,
   output logic [cega_pkg::FieldWidth-1:0]       rsp_new_start,
   output logic [cega_pkg::FieldWidth-1:0]       rsp_new_end,
   output logic [cega_pkg::OccWidth-1:0]         rsp_occupancy
);
   import cega_pkg::*;

   localparam logic [SizeWidth-1:0] DiskSize = SizeWidth'(DISK_BLOCKS);
   localparam logic [SizeWidth-1:0] SizeOne  = SizeWidth'(1);

   logic                   action_ff;
   logic [FieldWidth-1:0]  bidx_ff;
   logic                   bval_ff;
   logic [FieldWidth-1:0]  fs_ff;
   logic [FieldWidth-1:0]  fe_ff;
   logic [GrowWidth-1:0]   grow_ff;

   map_type                map_ff;
   map_type                file_bits_ff;
   map_type                window_ff;
   logic [PosWidth-1:0]    pos_ff;
   logic [SizeWidth-1:0]   nsz_ff;

   status_type             res_status_ff;
   logic [FieldWidth-1:0]  res_start_ff;
   logic [FieldWidth-1:0]  res_end_ff;

   logic                   rsp_valid_ff;
   logic [StatusWidth-1:0] rsp_status_ff;
   logic [FieldWidth-1:0]  rsp_start_ff;
   logic [FieldWidth-1:0]  rsp_end_ff;
   logic [OccWidth-1:0]    rsp_occ_ff;

   logic [SizeWidth-1:0]   fs_w;
   logic [SizeWidth-1:0]   fe_w;
   logic [SizeWidth-1:0]   grow_w;
   logic [SizeWidth-1:0]   pos_w;
   logic [SizeWidth-1:0]   ext_pos;
   logic [SizeWidth-1:0]   cur;
   logic [SizeWidth-1:0]   nsz;
   map_type                ext_mask;
   map_type                file_mask;
   map_type                wr_mask;
   logic                   invalid;
   logic                   inplace;
   logic                   in_range;

   always_comb begin
      fs_w      = SizeWidth'(fs_ff);
      fe_w      = SizeWidth'(fe_ff);
      grow_w    = SizeWidth'(grow_ff);
      pos_w     = SizeWidth'(pos_ff);
      invalid   = (fs_w > fe_w) || (fe_w >= DiskSize);
      ext_pos   = fe_w + SizeOne;
      ext_mask  = run_mask(ext_pos, grow_w);
      inplace   = ((ext_pos + grow_w) <= DiskSize) && ((map_ff & ext_mask) == '0);
      cur       = fe_w - fs_w + SizeOne;
      nsz       = cur + grow_w;
      file_mask = run_mask(fs_w, cur);
      wr_mask   = run_mask(SizeWidth'(bidx_ff), SizeOne);
      in_range  = (pos_w + nsz_ff) <= DiskSize;
   end

   assign sts.direct   = !action_ff || invalid || inplace;
   assign sts.in_range = in_range;
   assign sts.hit      = in_range && ((map_ff & window_ff) == '0);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         bidx_ff   <= req_block_index;
         bval_ff   <= req_block_value;
         fs_ff     <= req_file_start;
         fe_ff     <= req_file_end;
         grow_ff   <= req_grow_amount;
      end
      if (cmd.decide) begin
         priority if (!action_ff) begin
            res_status_ff <= RSP_WRITTEN;
            res_start_ff  <= '0;
            res_end_ff    <= '0;
         end else if (invalid) begin
            res_status_ff <= RSP_INVALID;
            res_start_ff  <= fs_ff;
            res_end_ff    <= fe_ff;
         end else if (inplace) begin
            res_status_ff <= RSP_EXTENDED;
            res_start_ff  <= fs_ff;
            res_end_ff    <= FieldWidth'(fe_w + grow_w);
         end else begin
            file_bits_ff <= file_mask;
            nsz_ff       <= nsz;
            pos_ff       <= '0;
            window_ff    <= run_mask('0, nsz);
         end
      end
      if (cmd.step) begin
         pos_ff    <= pos_ff + PosWidth'(1);
         window_ff <= window_ff << 1;
      end
      if (cmd.found) begin
         res_status_ff <= RSP_RELOCATED;
         res_start_ff  <= FieldWidth'(pos_ff);
         res_end_ff    <= FieldWidth'(pos_w + nsz_ff - SizeOne);
      end
      if (cmd.fail) begin
         res_status_ff <= RSP_FAILED;
         res_start_ff  <= fs_ff;
         res_end_ff    <= fe_ff;
      end
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_start_ff  <= res_start_ff;
         rsp_end_ff    <= res_end_ff;
         rsp_occ_ff    <= OccWidth'(map_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.decide) begin
            priority if (!action_ff) begin
               map_ff <= bval_ff ? (map_ff | wr_mask) : (map_ff & ~wr_mask);
            end else if (invalid) begin
               map_ff <= map_ff;
            end else if (inplace) begin
               map_ff <= map_ff | ext_mask;
            end else begin
               map_ff <= map_ff & ~file_mask;
            end
         end else if (cmd.found) begin
            map_ff <= map_ff | window_ff;
         end else if (cmd.fail) begin
            map_ff <= map_ff | file_bits_ff;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_new_start = rsp_start_ff;
   assign rsp_new_end   = rsp_end_ff;
   assign rsp_occupancy = rsp_occ_ff;

   a_found_claims_run: assert property (@(posedge clock) disable iff (reset)
      cmd.found |=> (map_ff & $past(window_ff)) == $past(window_ff))
      else $error("relocated run not marked used");

   a_invalid_keeps_map: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && action_ff && invalid) |=> map_ff == $past(map_ff))
      else $error("invalid request changed the bitmap");

   a_fail_restores_file: assert property (@(posedge clock) disable iff (reset)
      cmd.fail |=> (map_ff & $past(file_bits_ff)) == $past(file_bits_ff))
      else $error("failed request did not restore file blocks");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_ff <= StatusWidth'(RSP_INVALID))
      else $error("undefined status code");

endmodule

FILE: src/contiguous_extent_grow_allocator_core.sv
`timescale 1ns / 1ps
// Top level of the contiguous extent grow allocator: controller plus datapath.
// Depends on cega_pkg, cega_ctrl and cega_dp.
//
// One item is handled at a time and gives exactly one result. A block write, an
// invalid request or an in-place extension goes from transfer through the decision
// state to publishing; a request that needs relocation first runs the first-fit
// scan, which stops at the first free window or past the disk end. The scan slides
// one window position per cycle over the bitmap register. A finished result sits in
// an output register, so the next request can be taken while it waits to be drained.
module contiguous_extent_grow_allocator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [cega_pkg::FieldWidth-1:0]       req_block_index,
   input  logic                                  req_block_value,
   input  logic [cega_pkg::FieldWidth-1:0]       req_file_start,
   input  logic [cega_pkg::FieldWidth-1:0]       req_file_end,
   input  logic [cega_pkg::GrowWidth-1:0]        req_grow_amount,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cega_pkg::StatusWidth-1:0]      rsp_status,
   output logic [cega_pkg::FieldWidth-1:0]       rsp_new_start,
   output logic [cega_pkg::FieldWidth-1:0]       rsp_new_end,
   output logic [cega_pkg::OccWidth-1:0]         rsp_occupancy
);
   import cega_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cega_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cega_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_block_index (req_block_index),
      .req_block_value (req_block_value),
      .req_file_start  (req_file_start),
      .req_file_end    (req_file_end),
      .req_grow_amount (req_grow_amount),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_new_start   (rsp_new_start),
      .rsp_new_end     (rsp_new_end),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule

FILE: tb/extent_map_checker.sv
`timescale 1ns / 1ps
// Checker for the contiguous extent grow allocator: predicts each result from its own block map.
// Depends on cega_pkg for widths and status codes; the testbench top instantiates it on the core ports.
module extent_map_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_action,
   input  logic [cega_pkg::FieldWidth-1:0]   req_block_index,
   input  logic                              req_block_value,
   input  logic [cega_pkg::FieldWidth-1:0]   req_file_start,
   input  logic [cega_pkg::FieldWidth-1:0]   req_file_end,
   input  logic [cega_pkg::GrowWidth-1:0]    req_grow_amount,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [cega_pkg::StatusWidth-1:0]  rsp_status,
   input  logic [cega_pkg::FieldWidth-1:0]   rsp_new_start,
   input  logic [cega_pkg::FieldWidth-1:0]   rsp_new_end,
   input  logic [cega_pkg::OccWidth-1:0]     rsp_occupancy,
   output int                                error_count,
   output int                                pending_count
);
   import cega_pkg::*;

   typedef struct packed {
      status_type            status;
      logic [FieldWidth-1:0] first_blk;
      logic [FieldWidth-1:0] last_blk;
      logic [OccWidth-1:0]   occ;
   } alloc_outcome_t;

   bit [63:0]      disk_map;
   alloc_outcome_t pending_outcomes[$];
   int             fail_total;

   function automatic bit [63:0] span_bits(input int unsigned pos, input int unsigned len);
      bit [63:0] m;
      if (len == 0 || pos >= 64) return '0;
      m = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
      return m << pos;
   endfunction

   function automatic bit blocks_free(input int unsigned pos, input int unsigned len);
      if (pos + len > DISK_BLOCKS) return 1'b0;
      return (disk_map & span_bits(pos, len)) == '0;
   endfunction

   function automatic alloc_outcome_t predict_allocation(input logic act, input logic [4:0] bidx,
                                                         input logic bval, input logic [4:0] fs,
                                                         input logic [4:0] fe,
                                                         input logic [5:0] grow);
      alloc_outcome_t o;
      int unsigned    s, e, g, cur, nsz, i;
      bit [63:0]      file_bits;
      bit             found;
      o = '0;
      o.status = RSP_WRITTEN;
      s = fs;
      e = fe;
      g = grow;
      found = 1'b0;
      if (!act) begin
         if (int'(bidx) < DISK_BLOCKS) disk_map[bidx] = bval;
      end else if (s > e || e >= DISK_BLOCKS) begin
         o.status = RSP_INVALID;
         o.first_blk = fs;
         o.last_blk = fe;
      end else if (blocks_free(e + 1, g)) begin
         disk_map |= span_bits(e + 1, g);
         o.status = RSP_EXTENDED;
         o.first_blk = fs;
         o.last_blk = 5'(e + g);
      end else begin
         cur = e - s + 1;
         nsz = cur + g;
         file_bits = span_bits(s, cur);
         disk_map &= ~file_bits;
         if (nsz <= DISK_BLOCKS) begin
            for (i = 0; i + nsz <= DISK_BLOCKS && !found; i++) begin
               if (blocks_free(i, nsz)) begin
                  disk_map |= span_bits(i, nsz);
                  o.first_blk = 5'(i);
                  o.last_blk = 5'(i + nsz - 1);
                  found = 1'b1;
               end
            end
         end
         if (found) begin
            o.status = RSP_RELOCATED;
         end else begin
            disk_map |= file_bits;
            o.status = RSP_FAILED;
            o.first_blk = fs;
            o.last_blk = fe;
         end
      end
      disk_map &= span_bits(0, DISK_BLOCKS);
      o.occ = disk_map[OccWidth-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      alloc_outcome_t want;
      if (reset) begin
         disk_map = '0;
         pending_outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: result with nothing expected: status %0d occ %h",
                           $realtime, rsp_status, rsp_occupancy);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_new_start !== want.first_blk ||
                   rsp_new_end !== want.last_blk || rsp_occupancy !== want.occ) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display({"%0t: mismatch exp/act status %0d/%0d start %0d/%0d",
                               " end %0d/%0d occ %h/%h"},
                              $realtime, want.status, rsp_status, want.first_blk, rsp_new_start,
                              want.last_blk, rsp_new_end, want.occ, rsp_occupancy);
               end
            end
         end
         if (req_valid && !req_stall)
            pending_outcomes.push_back(predict_allocation(req_action, req_block_index,
                                                          req_block_value, req_file_start,
                                                          req_file_end, req_grow_amount));
      end
      error_count <= fail_total;
      pending_count <= pending_outcomes.size();
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for contiguous_extent_grow_allocator_core: clock, reset, stimulus and verdict.
// Depends on cega_pkg, the core RTL and extent_map_checker.
module tb;
   import cega_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_action;
   logic [FieldWidth-1:0]  req_block_index;
   logic                   req_block_value;
   logic [FieldWidth-1:0]  req_file_start;
   logic [FieldWidth-1:0]  req_file_end;
   logic [GrowWidth-1:0]   req_grow_amount;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [StatusWidth-1:0] rsp_status;
   logic [FieldWidth-1:0]  rsp_new_start;
   logic [FieldWidth-1:0]  rsp_new_end;
   logic [OccWidth-1:0]    rsp_occupancy;
   int                     error_count;
   int                     pending_count;

   contiguous_extent_grow_allocator_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_block_index (req_block_index),
      .req_block_value (req_block_value),
      .req_file_start  (req_file_start),
      .req_file_end    (req_file_end),
      .req_grow_amount (req_grow_amount),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_new_start   (rsp_new_start),
      .rsp_new_end     (rsp_new_end),
      .rsp_occupancy   (rsp_occupancy)
   );

   extent_map_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_block_index (req_block_index),
      .req_block_value (req_block_value),
      .req_file_start  (req_file_start),
      .req_file_end    (req_file_end),
      .req_grow_amount (req_grow_amount),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_new_start   (rsp_new_start),
      .rsp_new_end     (rsp_new_end),
      .rsp_occupancy   (rsp_occupancy),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   initial begin : drain_pacing
      int open_len;
      int hold_len;
      rsp_stall = 1'b0;
      forever begin
         open_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 10);
         repeat (open_len) @(negedge clock);
         hold_len = idle_len();
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic transfer_item(input logic act, input logic [4:0] bidx, input logic bval,
                                input logic [4:0] fs, input logic [4:0] fe,
                                input logic [5:0] grow);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_block_index <= bidx;
      req_block_value <= bval;
      req_file_start  <= fs;
      req_file_end    <= fe;
      req_grow_amount <= grow;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_block(input logic [4:0] bidx, input logic bval);
      transfer_item(1'b0, bidx, bval, 5'($urandom), 5'($urandom), 6'($urandom));
   endtask

   task automatic grow_file(input logic [4:0] fs, input logic [4:0] fe, input logic [5:0] grow);
      transfer_item(1'b1, 5'($urandom), 1'($urandom), fs, fe, grow);
   endtask

   task automatic drain_wait();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int n;
      int pick;
      int fs_i;
      int len_i;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = 1'b0;
      req_block_index = '0;
      req_block_value = 1'b0;
      req_file_start  = '0;
      req_file_end    = '0;
      req_grow_amount = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes of the write path
      write_block(5'd0, 1'b1);
      write_block(5'd31, 1'b1);
      write_block(5'd31, 1'b0);
      write_block(5'd0, 1'b0);
      // zero growth, then extend in place
      grow_file(5'd0, 5'd0, 6'd0);
      grow_file(5'd0, 5'd3, 6'd4);
      // blocked tail forces a relocation
      write_block(5'd10, 1'b1);
      grow_file(5'd8, 5'd9, 6'd3);
      // start after end, and an extent at the top of the disk
      grow_file(5'd5, 5'd4, 6'd1);
      grow_file(5'd31, 5'd0, 6'd0);
      grow_file(5'd28, 5'd31, 6'd1);
      grow_file(5'd31, 5'd31, 6'd0);
      // new size beyond the disk fails and leaves the whole extent used
      grow_file(5'd0, 5'd31, 6'd1);
      grow_file(5'd3, 5'd5, 6'd2);
      grow_file(5'd0, 5'd0, 6'd63);
      grow_file(5'd30, 5'd31, 6'd32);
      write_block(5'd16, 1'b0);
      write_block(5'd17, 1'b0);
      grow_file(5'd15, 5'd15, 6'd2);
      grow_file(5'd31, 5'd31, 6'd32);
      drain_wait();

      for (n = 0; n < 1000; n++) begin
         if (n == 500) drain_wait();
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            write_block(5'($urandom), ($urandom_range(0, 9) < 3));
         end else if (pick < 88) begin
            fs_i  = $urandom_range(0, 31);
            len_i = $urandom_range(0, (31 - fs_i < 7) ? 31 - fs_i : 7);
            grow_file(5'(fs_i), 5'(fs_i + len_i),
                      ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 6)));
         end else begin
            transfer_item(1'($urandom), 5'($urandom), 1'($urandom), 5'($urandom),
                          5'($urandom), 6'($urandom));
         end
      end

      drain_wait();
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
